// ===== rtl/knxr_pkg.sv =====
// ----------------------------------------------------------------------------
// knxr_pkg
// Shared types and constants for the pulse-bit character receiver.
// ----------------------------------------------------------------------------
package knxr_pkg;

    localparam int TIMESTAMP_BITS_DEFAULT = 16;
    localparam int WINDOW_BITS            = 16;
    localparam int PERIOD_BITS            = 17;
    localparam int BYTE_BITS              = 8;
    localparam int POS_BITS               = 4;
    localparam int CFG_INDEX_BITS         = 2;

    localparam logic [WINDOW_BITS-1:0] MIN_WIDTH_RESET = 16'd15;
    localparam logic [WINDOW_BITS-1:0] MAX_WIDTH_RESET = 16'd65;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET    = 17'h10000;

    localparam logic [POS_BITS-1:0] POS_START     = 4'd0;
    localparam logic [POS_BITS-1:0] POS_DATA_LAST = 4'd8;
    localparam logic [POS_BITS-1:0] POS_PARITY    = 4'd9;
    localparam logic [POS_BITS-1:0] POS_STOP      = 4'd10;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_WIDTH = 2'd0,
        CFG_MAX_WIDTH = 2'd1,
        CFG_PERIOD    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] min_width;
        logic [WINDOW_BITS-1:0] max_width;
        logic [PERIOD_BITS-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic                 awaiting_fall;
        logic                 pulse_seen;
        logic [POS_BITS-1:0]  bit_position;
        logic [BYTE_BITS-1:0] shift_byte;
        logic                 receiving;
    } frame_t;

    localparam frame_t FRAME_RESET = '{
        awaiting_fall: 1'b0,
        pulse_seen:    1'b0,
        bit_position:  POS_START,
        shift_byte:    '0,
        receiving:     1'b0
    };

endpackage

// ===== rtl/knxr_frame.sv =====
// ----------------------------------------------------------------------------
// knxr_frame
// Next-state logic for one event: pulse width check and character framing.
// ----------------------------------------------------------------------------
module knxr_frame
    import knxr_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
)
(
    input  cfg_t                      cfg,
    input  frame_t                    frame,
    input  logic [TIMESTAMP_BITS-1:0] rise_time,
    input  op_t                       operation,
    input  logic [TIMESTAMP_BITS-1:0] timestamp,
    output frame_t                    frame_next,
    output logic [TIMESTAMP_BITS-1:0] rise_time_next,
    output logic                      emit,
    output logic [BYTE_BITS-1:0]      emit_byte
);

    localparam int WB = TIMESTAMP_BITS + 1;
    localparam int CW = (WB > PERIOD_BITS) ? WB : PERIOD_BITS;

    logic [CW-1:0] period_ext;
    logic [CW-1:0] rise_ext;
    logic [CW-1:0] now_ext;
    logic [CW-1:0] wrap_sum;
    logic [CW-1:0] direct_diff;
    logic [WB-1:0] width;
    logic [CW-1:0] width_ext;
    logic          in_window;
    logic          bit_one;

    assign period_ext  = CW'(cfg.period);
    assign rise_ext    = CW'(rise_time);
    assign now_ext     = CW'(timestamp);
    assign wrap_sum    = period_ext - rise_ext + now_ext;
    assign direct_diff = now_ext - rise_ext;
    assign width       = (timestamp >= rise_time) ? direct_diff[WB-1:0] : wrap_sum[WB-1:0];
    assign width_ext   = CW'(width);
    assign in_window   = (width_ext >= CW'(cfg.min_width)) && (width_ext <= CW'(cfg.max_width));
    assign bit_one     = !frame.pulse_seen;
    assign emit_byte   = frame.shift_byte;

    always_comb
    begin
        frame_next     = frame;
        rise_time_next = rise_time;
        emit           = 1'b0;
        if (operation == OP_EDGE)
        begin
            if (!frame.awaiting_fall)
            begin
                rise_time_next           = timestamp;
                frame_next.awaiting_fall = 1'b1;
            end
            else
            begin
                frame_next.awaiting_fall = 1'b0;
                if (in_window)
                begin
                    frame_next.receiving  = 1'b1;
                    frame_next.pulse_seen = 1'b1;
                end
            end
        end
        else if (frame.receiving)
        begin
            frame_next.pulse_seen   = 1'b0;
            frame_next.bit_position = frame.bit_position + 1'b1;
            case (frame.bit_position)
                POS_START:
                begin
                    if (bit_one)
                    begin
                        frame_next               = FRAME_RESET;
                        frame_next.awaiting_fall = frame.awaiting_fall;
                    end
                end
                POS_PARITY:
                begin
                    frame_next.shift_byte = frame.shift_byte;
                end
                POS_STOP:
                begin
                    frame_next               = FRAME_RESET;
                    frame_next.awaiting_fall = frame.awaiting_fall;
                    emit                     = bit_one;
                end
                default:
                begin
                    if (frame.bit_position <= POS_DATA_LAST)
                    begin
                        frame_next.shift_byte = {bit_one, frame.shift_byte[BYTE_BITS-1:1]};
                    end
                    else
                    begin
                        frame_next               = FRAME_RESET;
                        frame_next.awaiting_fall = frame.awaiting_fall;
                        emit                     = bit_one;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/knx_pulse_bit_receiver.sv =====
// ----------------------------------------------------------------------------
// knx_pulse_bit_receiver
// Pulse-bit character receiver: edge/tick events in, framed data bytes out.
// ----------------------------------------------------------------------------
// Takes one event per clock. An accepted event is held in the input register,
// where the width check and framing update run; when that event fires, a
// completed byte is registered into the result register, from which it
// transfers out. The input side stalls only when the result register holds
// an untaken byte and the event in the input register would finish another
// one. Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module knx_pulse_bit_receiver
    import knxr_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [TIMESTAMP_BITS-1:0] timestamp,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [BYTE_BITS-1:0]      received_byte,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]    cfg_data
);

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    op_t                       s1_op_reg;
    logic [TIMESTAMP_BITS-1:0] s1_ts_reg;
    frame_t                    frame_reg;
    frame_t                    frame_next;
    logic [TIMESTAMP_BITS-1:0] rise_time_reg;
    logic [TIMESTAMP_BITS-1:0] rise_time_next;
    cfg_t                      cfg_reg;
    cfg_t                      cfg_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [BYTE_BITS-1:0]      out_byte_reg;
    logic                      emit;
    logic [BYTE_BITS-1:0]      emit_byte;
    logic                      out_free;
    logic                      fire;
    logic                      in_take;

    knxr_frame #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_frame (
        .cfg            (cfg_reg),
        .frame          (frame_reg),
        .rise_time      (rise_time_reg),
        .operation      (s1_op_reg),
        .timestamp      (s1_ts_reg),
        .frame_next     (frame_next),
        .rise_time_next (rise_time_next),
        .emit           (emit),
        .emit_byte      (emit_byte)
    );

    assign out_free      = !out_valid_reg || !out_stall;
    assign fire          = s1_valid_reg && (!emit || out_free);
    assign in_stall      = s1_valid_reg && !fire;
    assign in_take       = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign received_byte = out_byte_reg;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_WIDTH: cfg_next.min_width = cfg_data[WINDOW_BITS-1:0];
                CFG_MAX_WIDTH: cfg_next.max_width = cfg_data[WINDOW_BITS-1:0];
                CFG_PERIOD:    cfg_next.period    = cfg_data;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            frame_reg        <= FRAME_RESET;
            rise_time_reg    <= '0;
            cfg_reg.min_width <= MIN_WIDTH_RESET;
            cfg_reg.max_width <= MAX_WIDTH_RESET;
            cfg_reg.period    <= PERIOD_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (fire)
            begin
                frame_reg     <= frame_next;
                rise_time_reg <= rise_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg <= op_t'(operation);
            s1_ts_reg <= timestamp;
        end
        if (fire && emit)
        begin
            out_byte_reg <= emit_byte;
        end
    end

endmodule

// ===== rtl/knxr_checker.sv =====
// ----------------------------------------------------------------------------
// knxr_checker
// Port-level checks for the pulse-bit character receiver, bound to the top.
// ----------------------------------------------------------------------------
module knxr_checker
    import knxr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 operation,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [BYTE_BITS-1:0] received_byte
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(received_byte))
    else $error("held result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register is free");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(received_byte))
    else $error("result data unknown while valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && operation == OP_TICK, 2))
    else $error("result not caused by a tick transfer");

endmodule

bind knx_pulse_bit_receiver knxr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .received_byte (received_byte)
);

// ===== tb/sv/knx_pulse_bit_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// knx_pulse_bit_receiver_tb
// Drives edge and tick events into the pulse-bit character receiver under
// several pulse windows and counter periods. A scoreboard tracks the edge
// pairing and the character framing, and checks every byte that comes out.
// Both sides idle at random; the receiver also holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
import knxr_pkg::*;

class knx_byte_scoreboard;

    logic [WINDOW_BITS-1:0]            min_width;
    logic [WINDOW_BITS-1:0]            max_width;
    logic [PERIOD_BITS-1:0]            period;
    logic [TIMESTAMP_BITS_DEFAULT-1:0] rise_time;
    frame_t                            frame;
    logic [BYTE_BITS-1:0]              expected_bytes[$];
    int                                errors;
    int                                bytes_checked;
    int                                frames_dropped;
    int                                pulses_accepted;

    function new();
        min_width       = MIN_WIDTH_RESET;
        max_width       = MAX_WIDTH_RESET;
        period          = PERIOD_RESET;
        rise_time       = '0;
        frame           = FRAME_RESET;
        errors          = 0;
        bytes_checked   = 0;
        frames_dropped  = 0;
        pulses_accepted = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [PERIOD_BITS-1:0] value);
        case (idx)
            CFG_MIN_WIDTH: min_width = value[WINDOW_BITS-1:0];
            CFG_MAX_WIDTH: max_width = value[WINDOW_BITS-1:0];
            CFG_PERIOD:    period    = value;
            default:       ;
        endcase
    endfunction

    function void drop_frame();
        frame.bit_position = POS_START;
        frame.shift_byte   = '0;
        frame.pulse_seen   = 1'b0;
        frame.receiving    = 1'b0;
    endfunction

    function void note_event(op_t op, logic [TIMESTAMP_BITS_DEFAULT-1:0] ts);
        logic [PERIOD_BITS-1:0] width;
        logic                   data_one;
        if (op == OP_EDGE)
        begin
            if (!frame.awaiting_fall)
            begin
                rise_time           = ts;
                frame.awaiting_fall = 1'b1;
            end
            else
            begin
                if (ts >= rise_time)
                    width = {1'b0, ts} - {1'b0, rise_time};
                else
                    width = period - {1'b0, rise_time} + {1'b0, ts};
                frame.awaiting_fall = 1'b0;
                if (width >= {1'b0, min_width} && width <= {1'b0, max_width})
                begin
                    frame.receiving  = 1'b1;
                    frame.pulse_seen = 1'b1;
                    pulses_accepted++;
                end
            end
            return;
        end
        if (!frame.receiving)
            return;
        data_one         = !frame.pulse_seen;
        frame.pulse_seen = 1'b0;
        if (frame.bit_position == POS_START)
        begin
            if (data_one)
            begin
                frames_dropped++;
                drop_frame();
                return;
            end
        end
        else if (frame.bit_position <= POS_DATA_LAST)
        begin
            frame.shift_byte = {data_one, frame.shift_byte[BYTE_BITS-1:1]};
        end
        else if (frame.bit_position > POS_PARITY)
        begin
            if (data_one)
                expected_bytes.push_back(frame.shift_byte);
            else
                frames_dropped++;
            drop_frame();
            return;
        end
        frame.bit_position = frame.bit_position + 1'b1;
    endfunction

    function void check_byte(logic [BYTE_BITS-1:0] got);
        logic [BYTE_BITS-1:0] want;
        if (expected_bytes.size() == 0)
        begin
            $display("%0t: received_byte expected none got %02h", $time, got);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got !== want)
        begin
            $display("%0t: received_byte expected %02h got %02h", $time, want, got);
            errors++;
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

endclass

module knx_pulse_bit_receiver_tb;

    localparam int TS_BITS        = TIMESTAMP_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 155;
    localparam int NUM_PHASES     = 9;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      operation;
    logic [TS_BITS-1:0]        timestamp;
    logic                      out_valid;
    logic                      out_stall;
    logic [BYTE_BITS-1:0]      received_byte;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [PERIOD_BITS-1:0]    cfg_data;

    knx_byte_scoreboard sb;

    bit gaps_on;
    bit long_hold_req;
    int items_sent;
    int reg_writes;
    int cur_min;
    int cur_max;
    int cur_period;
    int idle_cycles;

    knx_pulse_bit_receiver #(.TIMESTAMP_BITS(TS_BITS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .received_byte (received_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hold off the result side in random bursts, or once for a long stretch
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12);
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_byte(received_byte);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_event(op_t op, logic [TS_BITS-1:0] ts);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        timestamp <= ts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_event(op, ts);
        items_sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= PERIOD_BITS'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, PERIOD_BITS'(value));
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_window(int lo, int hi, int per);
        write_reg(CFG_MIN_WIDTH, lo);
        write_reg(CFG_MAX_WIDTH, hi);
        write_reg(CFG_PERIOD, per);
        cur_min    = lo;
        cur_max    = hi;
        cur_period = per;
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // rise at a random count, fall after w counts, wrapping at the period
    task automatic send_pulse(int w);
        int rise;
        int sum;
        int fall;
        rise = $urandom_range(0, cur_period - 1);
        sum  = rise + w;
        fall = (sum < cur_period) ? sum : sum - cur_period;
        send_event(OP_EDGE, TS_BITS'(rise));
        send_event(OP_EDGE, TS_BITS'(fall));
    endtask

    function automatic int window_width();
        if (cur_min <= cur_max)
            return $urandom_range(cur_min, cur_max);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int noise_width();
        if (cur_max < 65535 && (cur_min == 0 || $urandom_range(0, 1) == 0))
        begin
            if ($urandom_range(0, 1) == 0)
                return $urandom_range(cur_max + 1, (cur_max + 200 > 65535) ? 65535 :
                                                   cur_max + 200);
            return $urandom_range(cur_max + 1, 65535);
        end
        if (cur_min > 0)
            return $urandom_range(0, cur_min - 1);
        return -1;
    endfunction

    task automatic send_char(logic [BYTE_BITS-1:0] data, bit bad_stop);
        logic [10:0] bits;
        int          w;
        bits = {~bad_stop, 1'($urandom_range(0, 1)), data, 1'b0};
        if (sb.frame.awaiting_fall)
            send_event(OP_EDGE, TS_BITS'($urandom));
        for (int k = 0; k < 11; k++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                w = noise_width();
                if (w >= 0)
                    send_pulse(w);
            end
            if (!bits[k])
                send_pulse(window_width());
            send_event(OP_TICK, TS_BITS'($urandom));
        end
    endtask

    initial
    begin
        int lo;
        int hi;
        int per;
        int phase_end;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_EDGE;
        timestamp     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MIN_WIDTH;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        items_sent    = 0;
        reg_writes    = 0;
        cur_min       = MIN_WIDTH_RESET;
        cur_max       = MAX_WIDTH_RESET;
        cur_period    = PERIOD_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tick while idle, then a wrapped minimum-width start pulse
        send_event(OP_TICK, '1);
        send_event(OP_EDGE, 16'hFFFF);
        send_event(OP_EDGE, 16'd14);
        send_event(OP_TICK, '0);
        send_event(OP_EDGE, 16'd100);
        send_event(OP_EDGE, 16'd166);
        send_event(OP_TICK, '0);
        send_event(OP_EDGE, 16'd0);
        send_event(OP_EDGE, 16'd65);
        repeat (9) send_event(OP_TICK, '0);
        // parity carries a pulse, and the stop tick is left unsent
        send_event(OP_EDGE, 16'h8000);
        send_event(OP_EDGE, 16'h8028);
        repeat (9) send_event(OP_TICK, '1);
        send_event(OP_EDGE, 16'h0100);
        send_event(OP_EDGE, 16'h0110);
        send_event(OP_TICK, '1);
        drain_block();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin lo = 15;    hi = 65;    per = 65536; end
                1: begin lo = 0;     hi = 65535; per = 65536; end
                2: begin lo = 0;     hi = 0;     per = 65536; end
                3: begin lo = 65535; hi = 65535; per = 65536; end
                4: begin lo = 200;   hi = 100;   per = 65536; end
                5: begin lo = 10;    hi = 40;    per = 1;     end
                8: begin lo = 15;    hi = 65;    per = 65536; end
                default:
                begin
                    lo  = $urandom_range(0, 3000);
                    hi  = lo + $urandom_range(0, 4000);
                    per = $urandom_range(hi + 1, 65536);
                end
            endcase
            apply_window(lo, hi, per);
            gaps_on = (ph != NUM_PHASES - 1);
            if (ph == 1)
                long_hold_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_event(op_t'($urandom_range(0, 1)), TS_BITS'($urandom));
                else if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 2)) send_event(OP_TICK, TS_BITS'($urandom));
                else
                    send_char(BYTE_BITS'($urandom), $urandom_range(0, 9) == 0);
            end
            drain_block();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: received_byte expected %02h got nothing (%0d left)",
                     $time, sb.expected_bytes[0], sb.pending());
            sb.errors++;
        end
        $display("Sent %0d events over %0d register writes; %0d pulses in window.",
                 items_sent, reg_writes, sb.pulses_accepted);
        $display("Checked %0d bytes, %0d frames dropped, %0d errors.",
                 sb.bytes_checked, sb.frames_dropped, sb.errors);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
